@@ src/tiny_register_machine_step_defines.svh @@
// Assertion macros for the tiny register machine step block.
// Used by the checker; needs a clock aclk and an active-low reset aresetn in scope.
`ifndef TINY_REGISTER_MACHINE_STEP_DEFINES_SVH
`define TINY_REGISTER_MACHINE_STEP_DEFINES_SVH

// Concurrent check that is switched off while reset is held.
`define TRMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define TRMS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ src/trms_pkg.sv @@
// Package for the tiny register machine step block: widths, operation codes,
// the instruction and control structs. Depends on nothing.
`timescale 1ns / 1ps

package trms_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int NUM_REGS_DEF  = 8;
    localparam int PROG_DEPTH    = 256;

    localparam int KIND_W    = 4;
    localparam int REG_IDX_W = 3;
    localparam int IMM_W     = 32;
    localparam int TGT_W     = 8;
    localparam int STEP_W    = 8;
    localparam int PC_W      = 9;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_PROG_LEN = 2'd0;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOP       = 4'd0,
        KIND_LOADCONST = 4'd1,
        KIND_COPY      = 4'd2,
        KIND_ADD       = 4'd3,
        KIND_SUB       = 4'd4,
        KIND_INC       = 4'd5,
        KIND_DEC       = 4'd6,
        KIND_MOVE      = 4'd7,
        KIND_JMP       = 4'd8,
        KIND_JNZ       = 4'd9
    } kind_t;

    typedef struct packed {
        kind_t                       kind;
        logic [REG_IDX_W-1:0]        source_reg;
        logic [REG_IDX_W-1:0]        dest_reg;
        logic [IMM_W-1:0]            immediate;
        logic [TGT_W-1:0]            jump_target;
        logic signed [STEP_W-1:0]    step_x;
        logic signed [STEP_W-1:0]    step_y;
    } instr_t;

    // Outcome of one executed step, handed from the execute unit to the pipeline.
    typedef struct packed {
        logic            wr_en;
        logic            wr_src;
        logic            halted;
        logic            move;
        logic            zero;
        logic [PC_W-1:0] pc;
    } ctl_t;

endpackage

@@ src/trms_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module trms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/trms_apb_cfg.sv @@
// APB configuration register holding the program length.
// Depends on trms_pkg.
`timescale 1ns / 1ps

module trms_apb_cfg
    import trms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [PC_W-1:0]       program_length
);

    logic [PC_W-1:0] prog_len_reg;
    logic [PC_W-1:0] prog_len_next;
    logic            wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == REG_PROG_LEN);

    always_comb begin
        prog_len_next = prog_len_reg;
        if (wr_hit) begin
            prog_len_next = pwdata[PC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_len_reg <= '0;
        end else begin
            prog_len_reg <= prog_len_next;
        end
    end

    assign prdata = (paddr == REG_PROG_LEN) ? APB_DATA_W'(prog_len_reg) : '0;
    assign program_length = prog_len_reg;

endmodule

@@ src/trms_exec.sv @@
// Execute unit: decodes one instruction against its operands, the counter and
// the zero flag, and gives the write-back value and step outcome. Depends on trms_pkg.
`timescale 1ns / 1ps

module trms_exec
    import trms_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int NUM_REGS  = NUM_REGS_DEF
) (
    input  instr_t                item,
    input  logic [WORD_BITS-1:0]  op_a,
    input  logic [WORD_BITS-1:0]  op_b,
    input  logic [PC_W-1:0]       pc_in,
    input  logic                  zero_in,
    input  logic [PC_W-1:0]       program_length,
    output logic [WORD_BITS-1:0]  wr_data,
    output ctl_t                  ctl
);

    logic writes;
    logic wr_src;
    logic jumped;
    logic halted;
    logic move;
    logic tgt_in_range;

    assign halted = (pc_in >= program_length) || (32'(pc_in) >= PROG_DEPTH);

    always_comb begin
        writes  = 1'b0;
        wr_src  = 1'b0;
        jumped  = 1'b0;
        wr_data = '0;
        move    = 1'b0;
        case (item.kind)
            KIND_LOADCONST: begin
                writes  = 1'b1;
                wr_src  = 1'b1;
                wr_data = WORD_BITS'(item.immediate);
            end
            KIND_COPY: begin
                writes  = 1'b1;
                wr_data = op_a;
            end
            KIND_ADD: begin
                writes  = 1'b1;
                wr_data = op_a + op_b;
            end
            KIND_SUB: begin
                // Source minus destination, written to the destination.
                writes  = 1'b1;
                wr_data = op_a - op_b;
            end
            KIND_INC: begin
                writes  = 1'b1;
                wr_src  = 1'b1;
                wr_data = op_a + WORD_BITS'(1);
            end
            KIND_DEC: begin
                writes  = 1'b1;
                wr_src  = 1'b1;
                wr_data = op_a - WORD_BITS'(1);
            end
            KIND_MOVE: begin
                move = !halted;
            end
            KIND_JMP: begin
                jumped = 1'b1;
            end
            KIND_JNZ: begin
                jumped = !zero_in;
            end
            default: begin
            end
        endcase
    end

    assign tgt_in_range = wr_src ? (32'(item.source_reg) < NUM_REGS)
                                 : (32'(item.dest_reg) < NUM_REGS);

    assign ctl.move   = move;
    assign ctl.wr_src = wr_src;
    assign ctl.halted = halted;
    assign ctl.wr_en  = writes && !halted && tgt_in_range;
    assign ctl.zero   = (writes && !halted) ? (wr_data == '0) : zero_in;
    assign ctl.pc     = halted ? pc_in
                      : jumped ? PC_W'(item.jump_target)
                      : pc_in + PC_W'(1);

endmodule

@@ src/tiny_register_machine_step.sv @@
// Top level of the tiny register machine step block.
// Depends on trms_pkg, trms_apb_cfg, trms_ram and trms_exec.
`timescale 1ns / 1ps

// This block executes one instruction of a small register machine for every
// input transfer and returns one result transfer for each. It takes one
// instruction per clock cycle when the result side keeps up. The operand
// addresses go to the register file in the cycle of the transfer and the
// instruction is held in the read stage; once the output register is free or
// drains, the instruction executes, writes back and loads the output register,
// which presents the result. The register file lives in two
// synchronous RAM copies (one per read port) that are written together; a
// write that lands in the same cycle as the next instruction's read is
// forwarded, so back-to-back dependent instructions see the new value. Every
// register reads as zero after reset through a valid bit per entry, so no
// clearing pass is needed. The counter and zero flag are kept in flip-flops
// and updated in the execute cycle. Once the counter reaches the program
// length, each instruction is answered with halted set and nothing changes.
// The program length is written through the APB port at byte address 0; the
// user must write it only while the block is idle, which the block does not enforce.
module tiny_register_machine_step
    import trms_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int NUM_REGS  = NUM_REGS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Instruction stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata from bit 0: source_reg[2:0], dest_reg[5:3], immediate[37:6],
    // jump_target[45:38], step_x[53:46], step_y[61:54], zero fill[63:62]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: kind[3:0]
    input  logic [KIND_W-1:0]     s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: next_pc[8:0], zero_out[9], move_x[17:10],
    // move_y[25:18], zero fill[31:26]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser from bit 0: halted[0], move_valid[1]
    output logic [M_TUSER_W-1:0]  m_tuser,
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [PC_W-1:0] program_length;

    // Read stage registers.
    logic                  s1_valid_reg;
    instr_t                s1_item_reg;
    logic                  s1_fwd_a_reg;
    logic                  s1_fwd_b_reg;
    logic                  s1_vld_a_reg;
    logic                  s1_vld_b_reg;
    logic [WORD_BITS-1:0]  fwd_data_reg;

    // Architectural state in flip-flops.
    logic [PC_W-1:0]       pc_reg;
    logic                  zero_reg;
    logic [NUM_REGS-1:0]   regs_valid_reg;

    // Output register.
    logic                  m_valid_reg;
    logic [PC_W-1:0]       m_pc_reg;
    logic                  m_zero_reg;
    logic                  m_halted_reg;
    logic                  m_move_reg;
    logic [STEP_W-1:0]     m_move_x_reg;
    logic [STEP_W-1:0]     m_move_y_reg;

    instr_t                in_item;
    logic                  s_fire;
    logic                  advance;
    logic [WORD_BITS-1:0]  rd_a;
    logic [WORD_BITS-1:0]  rd_b;
    logic [WORD_BITS-1:0]  op_a;
    logic [WORD_BITS-1:0]  op_b;
    logic [WORD_BITS-1:0]  wr_data;
    ctl_t                  ctl;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  wr_idx;
    logic [REG_AW-1:0]     wr_addr;
    logic                  rng_a;
    logic                  rng_b;
    logic                  hit_a;
    logic                  hit_b;

    trms_apb_cfg u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .program_length (program_length)
    );

    // Unpack the incoming transfer.
    assign in_item.kind        = kind_t'(s_tuser);
    assign in_item.source_reg  = s_tdata[2:0];
    assign in_item.dest_reg    = s_tdata[5:3];
    assign in_item.immediate   = s_tdata[37:6];
    assign in_item.jump_target = s_tdata[45:38];
    assign in_item.step_x      = s_tdata[53:46];
    assign in_item.step_y      = s_tdata[61:54];

    // The execute stage moves on whenever the output register is free or drains.
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // Write-back from the execute stage.
    assign wr_en   = advance && ctl.wr_en;
    assign wr_idx  = ctl.wr_src ? s1_item_reg.source_reg : s1_item_reg.dest_reg;
    assign wr_addr = REG_AW'(wr_idx);

    trms_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_REGS)
    ) u_ram_a (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (s_fire),
        .raddr (REG_AW'(in_item.source_reg)),
        .rdata (rd_a)
    );

    trms_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_REGS)
    ) u_ram_b (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (s_fire),
        .raddr (REG_AW'(in_item.dest_reg)),
        .rdata (rd_b)
    );

    // An index past the register count reads as zero; a register never written
    // since reset reads as zero through its valid bit.
    assign rng_a = 32'(in_item.source_reg) < NUM_REGS;
    assign rng_b = 32'(in_item.dest_reg) < NUM_REGS;
    assign hit_a = wr_en && (wr_idx == in_item.source_reg);
    assign hit_b = wr_en && (wr_idx == in_item.dest_reg);

    // A write in the same cycle as the read is not seen by the RAM output, so
    // it is taken from the forwarding register instead.
    assign op_a = s1_fwd_a_reg ? fwd_data_reg : (s1_vld_a_reg ? rd_a : '0);
    assign op_b = s1_fwd_b_reg ? fwd_data_reg : (s1_vld_b_reg ? rd_b : '0);

    trms_exec #(
        .WORD_BITS (WORD_BITS),
        .NUM_REGS  (NUM_REGS)
    ) u_exec (
        .item           (s1_item_reg),
        .op_a           (op_a),
        .op_b           (op_b),
        .pc_in          (pc_reg),
        .zero_in        (zero_reg),
        .program_length (program_length),
        .wr_data        (wr_data),
        .ctl            (ctl)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            pc_reg         <= '0;
            zero_reg       <= 1'b0;
            regs_valid_reg <= '0;
        end else begin
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                pc_reg      <= ctl.pc;
                zero_reg    <= ctl.zero;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                regs_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload of the read stage and of the output register.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_item_reg  <= in_item;
            s1_fwd_a_reg <= hit_a;
            s1_fwd_b_reg <= hit_b;
            s1_vld_a_reg <= rng_a && regs_valid_reg[REG_AW'(in_item.source_reg)];
            s1_vld_b_reg <= rng_b && regs_valid_reg[REG_AW'(in_item.dest_reg)];
            fwd_data_reg <= wr_data;
        end
        if (advance) begin
            m_pc_reg     <= ctl.pc;
            m_zero_reg   <= ctl.zero;
            m_halted_reg <= ctl.halted;
            m_move_reg   <= ctl.move;
            m_move_x_reg <= ctl.move ? s1_item_reg.step_x : '0;
            m_move_y_reg <= ctl.move ? s1_item_reg.step_y : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_move_y_reg, m_move_x_reg, m_zero_reg, m_pc_reg};
    assign m_tuser  = {m_move_reg, m_halted_reg};

endmodule

@@ src/trms_checker.sv @@
// Port-level checker for the tiny register machine step block, bound to the top level.
// Depends on trms_pkg and tiny_register_machine_step_defines.svh.
`timescale 1ns / 1ps
`include "tiny_register_machine_step_defines.svh"

module trms_checker
    import trms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser
);

    logic m_fire;

    assign m_fire = m_tvalid && m_tready;

    // A waiting result holds its value until it is taken.
    `TRMS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // A halted step never issues a move and carries zero offsets.
    `TRMS_ASSERT(a_halt_no_move, m_tvalid && m_tuser[0] |-> !m_tuser[1] && (m_tdata[25:10] == '0), "halted step issued a move")

    // A halted step leaves the counter where the previous step put it.
    `TRMS_ASSERT(a_halt_pc_holds, m_fire && $past(m_fire) && m_tuser[0] |-> m_tdata[8:0] == $past(m_tdata[8:0]), "counter moved on a halted step")

    // Reset empties the output register.
    `TRMS_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind tiny_register_machine_step trms_checker u_trms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
